### rtl/point_in_polygon_test_macros.svh
// Assertion macros shared by the checker of the polygon classifier.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// Same-cycle implication.
`define PPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ppt_pkg.sv
// Package: codes and the control struct passed along the edge cell chain.
package ppt_pkg;

	// Action codes of a command transaction
	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_QUERY  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// Relation codes of a response transaction
	localparam logic [1:0] REL_OUTSIDE  = 2'd0;
	localparam logic [1:0] REL_BOUNDARY = 2'd1;
	localparam logic [1:0] REL_INSIDE   = 2'd2;

	// Token kinds traveling through the chain
	localparam logic [1:0] TOK_IDLE   = 2'd0;
	localparam logic [1:0] TOK_APPEND = 2'd1;
	localparam logic [1:0] TOK_QUERY  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic       ovf;
		logic       on_bnd;
		logic       parity;
	} ctrl_t;

endpackage

### rtl/ppt_cell.sv
// Edge cell: holds one vertex and tests one polygon edge against a passing query; cell 0 tests no edge.
module ppt_cell #(
	parameter int INDEX       = 0,
	parameter int COORD_WIDTH = 16,
	parameter int CNT_WIDTH   = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  ppt_pkg::ctrl_t                up_ctrl,
	input  logic [CNT_WIDTH-1:0]          up_cnt,
	input  logic signed [COORD_WIDTH-1:0] up_px,
	input  logic signed [COORD_WIDTH-1:0] up_py,
	input  logic signed [COORD_WIDTH-1:0] up_ux,
	input  logic signed [COORD_WIDTH-1:0] up_uy,
	input  logic signed [COORD_WIDTH-1:0] up_v0x,
	input  logic signed [COORD_WIDTH-1:0] up_v0y,
	output ppt_pkg::ctrl_t                dn_ctrl,
	output logic [CNT_WIDTH-1:0]          dn_cnt,
	output logic signed [COORD_WIDTH-1:0] dn_px,
	output logic signed [COORD_WIDTH-1:0] dn_py,
	output logic signed [COORD_WIDTH-1:0] dn_ux,
	output logic signed [COORD_WIDTH-1:0] dn_uy,
	output logic signed [COORD_WIDTH-1:0] dn_v0x,
	output logic signed [COORD_WIDTH-1:0] dn_v0y
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * COORD_WIDTH + 2;
	localparam int CW = 2 * COORD_WIDTH + 3;
	localparam logic [CNT_WIDTH-1:0] IDX_N = CNT_WIDTH'(INDEX);
	localparam bit HAS_EDGE = (INDEX != 0);
	localparam bit IS_HEAD  = (INDEX == 0);

	logic signed [COORD_WIDTH-1:0] own_x_q, own_y_q;

	logic                          own_live, act;
	logic signed [COORD_WIDTH-1:0] vx, vy;
	logic signed [DW-1:0]          dux, duy, dvx, dvy;
	logic                          in_x, in_y, swap, span;

	ppt_pkg::ctrl_t                ctrl_s1;
	logic [CNT_WIDTH-1:0]          cnt_s1;
	logic signed [COORD_WIDTH-1:0] px_s1, py_s1, ux_s1, uy_s1, v0x_s1, v0y_s1;
	logic                          act_s1, box_s1, span_s1, swap_s1;
	logic signed [PW-1:0]          pa_s1, pb_s1;

	logic signed [CW-1:0]          cross_val;
	logic                          zero, neg, pos, hit, toggle;
	ppt_pkg::ctrl_t                ctrl_nxt;

	ppt_pkg::ctrl_t                ctrl_s2;
	logic [CNT_WIDTH-1:0]          cnt_s2;
	logic signed [COORD_WIDTH-1:0] px_s2, py_s2, ux_s2, uy_s2, v0x_s2, v0y_s2;

	// Store the vertex when an append addressed to this cell passes
	always_ff @(posedge clk) begin
		if (adv && up_ctrl.kind == ppt_pkg::TOK_APPEND && up_cnt == IDX_N) begin
			own_x_q <= up_px;
			own_y_q <= up_py;
		end
	end

	// Edge runs from the previous vertex to this one, or closes back to vertex 0
	always_comb begin
		own_live = IDX_N < up_cnt;
		vx       = own_live ? own_x_q : up_v0x;
		vy       = own_live ? own_y_q : up_v0y;
		act      = (up_ctrl.kind == ppt_pkg::TOK_QUERY) && HAS_EDGE && (IDX_N <= up_cnt);
		dux      = DW'(up_ux) - DW'(up_px);
		duy      = DW'(up_uy) - DW'(up_py);
		dvx      = DW'(vx) - DW'(up_px);
		dvy      = DW'(vy) - DW'(up_py);
		in_x     = (up_px >= up_ux && up_px <= vx) || (up_px >= vx && up_px <= up_ux);
		in_y     = (up_py >= up_uy && up_py <= vy) || (up_py >= vy && up_py <= up_uy);
		swap     = up_uy <= vy;
		span     = swap ? (up_uy < up_py && up_py <= vy) : (vy < up_py && up_py <= up_uy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			act_s1  <= 1'b0;
		end else if (adv) begin
			ctrl_s1 <= up_ctrl;
			act_s1  <= act;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_s1  <= up_cnt;
			px_s1   <= up_px;
			py_s1   <= up_py;
			ux_s1   <= own_x_q;
			uy_s1   <= own_y_q;
			v0x_s1  <= IS_HEAD ? own_x_q : up_v0x;
			v0y_s1  <= IS_HEAD ? own_y_q : up_v0y;
			pa_s1   <= dux * dvy;
			pb_s1   <= dvx * duy;
			box_s1  <= in_x && in_y;
			span_s1 <= span;
			swap_s1 <= swap;
		end
	end

	// Sign of the cross product decides collinearity and side
	always_comb begin
		cross_val       = CW'(pa_s1) - CW'(pb_s1);
		zero            = cross_val == '0;
		neg             = cross_val[CW-1];
		pos             = !neg && !zero;
		hit             = act_s1 && box_s1 && zero;
		toggle          = act_s1 && span_s1 && (swap_s1 ? neg : pos);
		ctrl_nxt        = ctrl_s1;
		ctrl_nxt.on_bnd = ctrl_s1.on_bnd | hit;
		ctrl_nxt.parity = ctrl_s1.parity ^ toggle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s2 <= ctrl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_s2 <= cnt_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			ux_s2  <= ux_s1;
			uy_s2  <= uy_s1;
			v0x_s2 <= v0x_s1;
			v0y_s2 <= v0y_s1;
		end
	end

	assign dn_ctrl = ctrl_s2;
	assign dn_cnt  = cnt_s2;
	assign dn_px   = px_s2;
	assign dn_py   = py_s2;
	assign dn_ux   = ux_s2;
	assign dn_uy   = uy_s2;
	assign dn_v0x  = v0x_s2;
	assign dn_v0y  = v0y_s2;

endmodule

### rtl/point_in_polygon_test.sv
// Top level: polygon vertex chain and crossing-number point classifier.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------
//  cmd     | cmd_valid / cmd_stall | action, coord_x, coord_y
//  rsp     | rsp_valid / rsp_stall | relation, overflowed
//
// One command transaction is taken per cycle while cmd_stall is low. A query
// passes MAX_VERTICES+1 edge cells on its way to rsp (the last cell tests the
// closing edge of a full polygon), and each cell takes two register stages.
// Reset clears the vertex count, the overflow flag and all chain token kinds.
// rsp_stall holds the chain only while a query sits at its end and the
// response register is full; cmd_stall follows in the same cycle.
module point_in_polygon_test #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_WIDTH  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [1:0]                    action,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [1:0]                    relation,
	output logic                          overflowed
);

	localparam int CNT_WIDTH = $clog2(MAX_VERTICES + 1);
	localparam int LINKS     = MAX_VERTICES + 2;
	localparam logic [CNT_WIDTH-1:0] MAX_N = CNT_WIDTH'(MAX_VERTICES);

	logic [CNT_WIDTH-1:0] count_q;
	logic                 ovf_q;
	logic                 accept, full, adv, tail_query;
	ppt_pkg::ctrl_t       entry_ctrl;

	logic                 rsp_valid_q, overflowed_q;
	logic [1:0]           relation_q, relation_nxt;

	ppt_pkg::ctrl_t                link_ctrl [LINKS];
	logic [CNT_WIDTH-1:0]          link_cnt  [LINKS];
	logic signed [COORD_WIDTH-1:0] link_px   [LINKS];
	logic signed [COORD_WIDTH-1:0] link_py   [LINKS];
	logic signed [COORD_WIDTH-1:0] link_ux   [LINKS];
	logic signed [COORD_WIDTH-1:0] link_uy   [LINKS];
	logic signed [COORD_WIDTH-1:0] link_v0x  [LINKS];
	logic signed [COORD_WIDTH-1:0] link_v0y  [LINKS];

	assign tail_query = link_ctrl[LINKS-1].kind == ppt_pkg::TOK_QUERY;
	assign adv        = !tail_query || !rsp_valid_q || !rsp_stall;
	assign cmd_stall  = !adv;
	assign accept     = cmd_valid && adv;
	assign full       = count_q == MAX_N;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			unique case (action)
				ppt_pkg::ACT_APPEND: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + CNT_WIDTH'(1);
					end
				end
				ppt_pkg::ACT_CLEAR: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Build the token that enters the chain; dropped appends become bubbles
	always_comb begin
		entry_ctrl      = '0;
		entry_ctrl.kind = ppt_pkg::TOK_IDLE;
		entry_ctrl.ovf  = ovf_q;
		if (accept) begin
			unique case (action)
				ppt_pkg::ACT_APPEND: begin
					if (!full) begin
						entry_ctrl.kind = ppt_pkg::TOK_APPEND;
					end
				end
				ppt_pkg::ACT_QUERY: begin
					entry_ctrl.kind = ppt_pkg::TOK_QUERY;
				end
				default: begin
				end
			endcase
		end
	end

	assign link_ctrl[0] = entry_ctrl;
	assign link_cnt[0]  = count_q;
	assign link_px[0]   = coord_x;
	assign link_py[0]   = coord_y;
	assign link_ux[0]   = '0;
	assign link_uy[0]   = '0;
	assign link_v0x[0]  = '0;
	assign link_v0y[0]  = '0;

	for (genvar k = 0; k <= MAX_VERTICES; k++) begin : g_cell
		ppt_cell #(
			.INDEX       (k),
			.COORD_WIDTH (COORD_WIDTH),
			.CNT_WIDTH   (CNT_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.up_ctrl (link_ctrl[k]),
			.up_cnt  (link_cnt[k]),
			.up_px   (link_px[k]),
			.up_py   (link_py[k]),
			.up_ux   (link_ux[k]),
			.up_uy   (link_uy[k]),
			.up_v0x  (link_v0x[k]),
			.up_v0y  (link_v0y[k]),
			.dn_ctrl (link_ctrl[k+1]),
			.dn_cnt  (link_cnt[k+1]),
			.dn_px   (link_px[k+1]),
			.dn_py   (link_py[k+1]),
			.dn_ux   (link_ux[k+1]),
			.dn_uy   (link_uy[k+1]),
			.dn_v0x  (link_v0x[k+1]),
			.dn_v0y  (link_v0y[k+1])
		);
	end

	// Boundary hit overrides parity
	assign relation_nxt = link_ctrl[LINKS-1].on_bnd ? ppt_pkg::REL_BOUNDARY :
		(link_ctrl[LINKS-1].parity ? ppt_pkg::REL_INSIDE : ppt_pkg::REL_OUTSIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv && tail_query) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail_query) begin
			relation_q   <= relation_nxt;
			overflowed_q <= link_ctrl[LINKS-1].ovf;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign relation   = relation_q;
	assign overflowed = overflowed_q;

endmodule

### rtl/ppt_checker.sv
// Checker on the top-level ports of the polygon classifier, with its bind.
`include "point_in_polygon_test_macros.svh"

module ppt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [1:0] relation,
	input logic       overflowed
);

	`PPT_ASSERT_NEXT(a_rsp_hold, clk, !arst_n, rsp_valid && rsp_stall, rsp_valid,
		"rsp_valid dropped while stalled")
	`PPT_ASSERT_NEXT(a_rsp_stable, clk, !arst_n, rsp_valid && rsp_stall,
		$stable(relation) && $stable(overflowed), "rsp payload changed while stalled")
	`PPT_ASSERT_NOW(a_cmd_stall_cause, clk, !arst_n, cmd_stall, rsp_valid && rsp_stall,
		"cmd stalled without a blocked response")
	`PPT_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !arst_n, !rsp_valid,
		"response valid after a reset cycle")

endmodule

bind point_in_polygon_test ppt_checker u_ppt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_stall  (cmd_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.relation   (relation),
	.overflowed (overflowed)
);

### dv/tb.sv
// Testbench for the point-in-polygon classifier: queued driver, monitor and scoreboard.
`timescale 1ns / 1ps

module tb;

	localparam int MAX_VTX = 64;
	localparam int COORD_W = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 300;
	localparam int LONG_HOLD = 600;
	localparam logic [1:0] ACT_NOP = 2'd3;

	typedef struct {
		logic [1:0]                act;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} cmd_t;

	typedef struct packed {
		logic [1:0] relation;
		logic       overflowed;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic [1:0] action = ppt_pkg::ACT_APPEND;
	logic signed [COORD_W-1:0] coord_x = '0;
	logic signed [COORD_W-1:0] coord_y = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [1:0] relation;
	logic overflowed;

	cmd_t cmd_queue[$];
	rsp_t expected_rsp[$];

	// polygon state as the block should hold it
	longint vtx_x[MAX_VTX];
	longint vtx_y[MAX_VTX];
	int     vtx_count = 0;
	bit     vtx_ovf = 1'b0;

	// polygon as the stimulus generator last built it
	longint gen_x[$];
	longint gen_y[$];

	int mismatch_count = 0;
	int items_queued = 0;
	int send_idle_pct = 24;
	int recv_idle_pct = 67;
	bit hold_armed = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	point_in_polygon_test #(
		.MAX_VERTICES(MAX_VTX),
		.COORD_WIDTH (COORD_W)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.action    (action),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.relation  (relation),
		.overflowed(overflowed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// On each edge the boundary test comes first, then half-open crossing parity.
	function automatic logic [1:0] classify_point(input longint px, input longint py);
		int j;
		longint ux, uy, vx, vy, t;
		bit parity;
		parity = 1'b0;
		for (int i = 0; i < vtx_count; i++) begin
			j = (i + 1 < vtx_count) ? i + 1 : 0;
			ux = vtx_x[i];
			uy = vtx_y[i];
			vx = vtx_x[j];
			vy = vtx_y[j];
			if ((vx - ux) * (py - uy) - (px - ux) * (vy - uy) == 0 &&
					px >= ((ux < vx) ? ux : vx) && px <= ((ux < vx) ? vx : ux) &&
					py >= ((uy < vy) ? uy : vy) && py <= ((uy < vy) ? vy : uy))
				return ppt_pkg::REL_BOUNDARY;
			// put the higher end first
			if (uy <= vy) begin
				t = ux; ux = vx; vx = t;
				t = uy; uy = vy; vy = t;
			end
			if (py > uy || py <= vy)
				continue;
			if ((ux - px) * (vy - py) - (vx - px) * (uy - py) > 0)
				parity = ~parity;
		end
		return parity ? ppt_pkg::REL_INSIDE : ppt_pkg::REL_OUTSIDE;
	endfunction

	function automatic longint rand_coord(input longint lo, input longint hi);
		return lo + longint'($urandom_range(int'(hi - lo)));
	endfunction

	task automatic queue_cmd(input logic [1:0] act, input longint x, input longint y);
		cmd_t c;
		c.act = act;
		c.x = x[COORD_W-1:0];
		c.y = y[COORD_W-1:0];
		cmd_queue = {cmd_queue, c};
		if (act != ACT_NOP)
			items_queued++;
		if (act == ppt_pkg::ACT_APPEND && gen_x.size() < MAX_VTX) begin
			gen_x = {gen_x, longint'(c.x)};
			gen_y = {gen_y, longint'(c.y)};
		end else if (act == ppt_pkg::ACT_CLEAR) begin
			gen_x.delete();
			gen_y.delete();
		end
	endtask

	// Aim queries at vertices, exact edge points, near misses and open space.
	task automatic pick_query_point(input longint lo, input longint hi,
			output longint qx, output longint qy);
		int kind, i, j;
		longint dx, dy, a, b, t, g, k;
		kind = $urandom_range(99);
		if (gen_x.size() == 0 || (kind >= 45 && kind < 75)) begin
			qx = rand_coord(lo, hi);
			qy = rand_coord(lo, hi);
		end else if (kind >= 75 && kind < 85) begin
			qx = rand_coord(-32768, 32767);
			qy = rand_coord(-32768, 32767);
		end else begin
			i = $urandom_range(gen_x.size() - 1);
			qx = gen_x[i];
			qy = gen_y[i];
			if (kind >= 20 && kind < 45) begin
				j = (i + 1 < gen_x.size()) ? i + 1 : 0;
				dx = gen_x[j] - gen_x[i];
				dy = gen_y[j] - gen_y[i];
				a = (dx < 0) ? -dx : dx;
				b = (dy < 0) ? -dy : dy;
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				g = a;
				if (g != 0) begin
					k = longint'($urandom_range(int'(g)));
					qx = gen_x[i] + dx / g * k;
					qy = gen_y[i] + dy / g * k;
				end
			end else if (kind >= 85) begin
				if ($urandom_range(1))
					qx = qx + (($urandom_range(1)) ? 1 : -1);
				else
					qy = qy + (($urandom_range(1)) ? 1 : -1);
			end
		end
	endtask

	// Mostly clear / build polygon / query runs, with some raw noise mixed in.
	task automatic queue_random_runs(input int target);
		int start, n, nq, sel;
		longint lo, hi, qx, qy;
		start = items_queued;
		while (items_queued - start < target) begin
			sel = $urandom_range(99);
			if (sel < 50) begin
				lo = -8;
				hi = 8;
			end else if (sel < 70) begin
				lo = -1000;
				hi = 1000;
			end else begin
				lo = -32768;
				hi = 32767;
			end
			if ($urandom_range(99) < 8) begin
				repeat ($urandom_range(1, 6))
					queue_cmd(2'($urandom_range(3)), rand_coord(-32768, 32767),
						rand_coord(-32768, 32767));
			end else begin
				if ($urandom_range(99) < 92)
					queue_cmd(ppt_pkg::ACT_CLEAR, rand_coord(-32768, 32767),
						rand_coord(-32768, 32767));
				sel = $urandom_range(99);
				if (sel < 10)
					n = $urandom_range(60, 70);
				else if (sel < 20)
					n = $urandom_range(2);
				else
					n = $urandom_range(3, 8);
				for (int v = 0; v < n; v++) begin
					// repeat a vertex now and then for degenerate edges
					if (gen_x.size() != 0 && $urandom_range(99) < 5)
						queue_cmd(ppt_pkg::ACT_APPEND, gen_x[gen_x.size() - 1],
							gen_y[gen_y.size() - 1]);
					else
						queue_cmd(ppt_pkg::ACT_APPEND, rand_coord(lo, hi), rand_coord(lo, hi));
				end
				nq = $urandom_range(2, 8);
				repeat (nq) begin
					pick_query_point(lo, hi, qx, qy);
					queue_cmd(ppt_pkg::ACT_QUERY, qx, qy);
				end
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || cmd_valid || expected_rsp.size() != 0);
	endtask

	// sender: present the next transaction once the current one is taken
	always @(posedge clk or negedge arst_n) begin : driver
		cmd_t c;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || !cmd_stall) begin
			if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				c = cmd_queue.pop_front();
				cmd_valid <= 1'b1;
				action <= c.act;
				coord_x <= c.x;
				coord_y <= c.y;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall, plus one long hold-off when armed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_armed && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= LONG_HOLD;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				case (action)
					ppt_pkg::ACT_APPEND: begin
						if (vtx_count < MAX_VTX) begin
							vtx_x[vtx_count] = longint'(coord_x);
							vtx_y[vtx_count] = longint'(coord_y);
							vtx_count++;
						end else begin
							vtx_ovf = 1'b1;
						end
					end
					ppt_pkg::ACT_CLEAR: begin
						vtx_count = 0;
						vtx_ovf = 1'b0;
					end
					ppt_pkg::ACT_QUERY: begin
						want.relation = classify_point(longint'(coord_x), longint'(coord_y));
						want.overflowed = vtx_ovf;
						expected_rsp = {expected_rsp, want};
					end
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$error("response transaction with none expected: relation %0d overflowed %0d",
						relation, overflowed);
					mismatch_count++;
				end else begin
					want = expected_rsp.pop_front();
					if (relation !== want.relation) begin
						$error("relation: expected %0d, actual %0d", want.relation, relation);
						mismatch_count++;
					end
					if (overflowed !== want.overflowed) begin
						$error("overflowed: expected %0d, actual %0d", want.overflowed, overflowed);
						mismatch_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// empty polygon and the unused action code
		queue_cmd(ppt_pkg::ACT_QUERY, -32768, 32767);
		queue_cmd(ACT_NOP, 32767, -32768);
		queue_cmd(ppt_pkg::ACT_QUERY, 0, 0);
		// single vertex
		queue_cmd(ppt_pkg::ACT_APPEND, 5, 5);
		queue_cmd(ppt_pkg::ACT_QUERY, 5, 5);
		queue_cmd(ppt_pkg::ACT_QUERY, 5, 6);
		// extreme triangle with a horizontal base
		queue_cmd(ppt_pkg::ACT_CLEAR, 0, 0);
		queue_cmd(ppt_pkg::ACT_APPEND, -32768, -32768);
		queue_cmd(ppt_pkg::ACT_APPEND, 32767, -32768);
		queue_cmd(ppt_pkg::ACT_APPEND, 0, 32767);
		queue_cmd(ppt_pkg::ACT_QUERY, 0, 0);
		queue_cmd(ppt_pkg::ACT_QUERY, -32768, -32768);
		queue_cmd(ppt_pkg::ACT_QUERY, 0, -32768);
		queue_cmd(ppt_pkg::ACT_QUERY, 32767, 32767);
		queue_cmd(ppt_pkg::ACT_QUERY, -32768, 32767);
		// square: ray through vertices and along horizontal edges
		queue_cmd(ppt_pkg::ACT_CLEAR, -1, -1);
		queue_cmd(ppt_pkg::ACT_APPEND, 0, 0);
		queue_cmd(ppt_pkg::ACT_APPEND, 10, 0);
		queue_cmd(ppt_pkg::ACT_APPEND, 10, 10);
		queue_cmd(ppt_pkg::ACT_APPEND, 0, 10);
		queue_cmd(ppt_pkg::ACT_QUERY, 5, 5);
		queue_cmd(ppt_pkg::ACT_QUERY, 10, 5);
		queue_cmd(ppt_pkg::ACT_QUERY, -5, 10);
		queue_cmd(ppt_pkg::ACT_QUERY, -5, 0);
		queue_cmd(ppt_pkg::ACT_QUERY, 5, 10);

		queue_random_runs(300);
		do
			@(negedge clk);
		while (cmd_queue.size() != 0);

		send_idle_pct = 67;
		recv_idle_pct = 24;
		queue_random_runs(300);
		// hold the sender until every response is back
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_runs(325);
		hold_armed = 1'b1;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_rsp.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_cell.sv
rtl/point_in_polygon_test.sv
rtl/ppt_checker.sv
dv/tb.sv
